// ===== sv/hrwc_pkg.sv =====
package hrwc_pkg;

  // Field widths of the stream items
  localparam int unsigned STAMP_W     = 52;
  localparam int unsigned SEC_W       = 32;
  localparam int unsigned USEC_W      = 20;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned WORDS_W     = 4;
  localparam int unsigned HDR_W       = 8;
  localparam int unsigned WINDOW_W    = 32;
  localparam int unsigned INDEX_W     = 32;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned IN_DATA_W   = 96;
  localparam int unsigned OUT_DATA_W  = 40;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  // Input tdata layout, lowest bit first
  localparam int unsigned IHL_LSB     = 0;
  localparam int unsigned DOFF_LSB    = 4;
  localparam int unsigned PORT_LSB    = 8;
  localparam int unsigned CAPLEN_LSB  = 24;
  localparam int unsigned SEC_LSB     = 40;
  localparam int unsigned USEC_LSB    = 72;

  // Arithmetic constants
  localparam logic [HDR_W-1:0]    LINK_HEADER_BYTES = 8'd14;
  localparam logic [USEC_W-1:0]   USEC_PER_SEC      = 20'd1000000;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET      = 32'd1000000;
  localparam logic [PORT_W-1:0]   EXCL_PORT_RESET   = 16'd80;

  // Configuration register index (taken from paddr[2])
  typedef enum logic [0:0] {
    REG_WINDOW_US     = 1'b0,
    REG_EXCLUDED_PORT = 1'b1
  } hrwc_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SCAN,
    ST_PUSH,
    ST_FLUSH,
    ST_FIN
  } hrwc_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // latch the input item
    logic calc;     // form the microsecond time stamp
    logic pop;      // report the oldest entry and drop it
    logic sat;      // flag that report as saturated
    logic push;     // store the new time stamp
    logic finish;   // send the held result as the last one
  } hrwc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_cmd;     // item on the input is an end-of-capture command
    logic in_req;     // item on the input is a request
    logic fill_nz;    // queue holds entries
    logic full;       // queue is full
    logic outside;    // new time is beyond the oldest entry's window
    logic out_free;   // output register can take a result this cycle
    logic hold_valid; // a result waits in the hold register
  } hrwc_status_t;

endpackage

// ===== sv/hrwc_ram.sv =====
module hrwc_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/hrwc_regs.sv =====
module hrwc_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hrwc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [hrwc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [hrwc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [hrwc_pkg::WINDOW_W-1:0]     window_us_o,
  output logic [hrwc_pkg::PORT_W-1:0]       excluded_port_o
);

  import hrwc_pkg::*;

  logic [WINDOW_W-1:0] window_q;
  logic [PORT_W-1:0]   excl_q;
  logic                wr_en;
  hrwc_reg_e           reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = hrwc_reg_e'(paddr[2]);

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
      excl_q   <= EXCL_PORT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_WINDOW_US:     window_q <= pwdata[WINDOW_W-1:0];
        REG_EXCLUDED_PORT: excl_q   <= pwdata[PORT_W-1:0];
        default:           ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      REG_WINDOW_US:     prdata = window_q;
      REG_EXCLUDED_PORT: prdata = {{(APB_DATA_W-PORT_W){1'b0}}, excl_q};
      default:           prdata = '0;
    endcase
  end

  assign window_us_o     = window_q;
  assign excluded_port_o = excl_q;

endmodule

// ===== sv/hrwc_ctrl.sv =====
module hrwc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  hrwc_pkg::hrwc_status_t status_i,
  output hrwc_pkg::hrwc_cmd_t    cmd_o
);

  import hrwc_pkg::*;

  hrwc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (status_i.in_cmd) begin
            state_d = ST_FLUSH;
          end else if (status_i.in_req) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!(status_i.fill_nz && status_i.outside)) begin
          if (!status_i.full || status_i.out_free) begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        state_d = status_i.hold_valid ? ST_FIN : ST_IDLE;
      end
      ST_FLUSH: begin
        if (!status_i.fill_nz) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!status_i.hold_valid || status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.load      = s_axis_tvalid_i;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
      end
      ST_SCAN: begin
        if (status_i.fill_nz && status_i.outside) begin
          cmd_o.pop = status_i.out_free;
        end else if (status_i.full) begin
          cmd_o.pop = status_i.out_free;
          cmd_o.sat = 1'b1;
        end
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
      end
      ST_FLUSH: begin
        cmd_o.pop = status_i.fill_nz & status_i.out_free;
      end
      ST_FIN: begin
        cmd_o.finish = status_i.hold_valid & status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/hrwc_dp.sv =====
module hrwc_dp #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hrwc_pkg::hrwc_cmd_t                cmd_i,
  output hrwc_pkg::hrwc_status_t             status_o,
  input  logic [hrwc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tuser_i,
  input  logic [hrwc_pkg::WINDOW_W-1:0]      window_us_i,
  input  logic [hrwc_pkg::PORT_W-1:0]        excluded_port_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [hrwc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  import hrwc_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = AW + 1;

  // Input field view
  logic [WORDS_W-1:0] in_ihl, in_doff;
  logic [PORT_W-1:0]  in_port;
  logic [LEN_W-1:0]   in_caplen;
  logic [HDR_W-1:0]   in_hdr;

  assign in_ihl    = s_axis_tdata_i[IHL_LSB +: WORDS_W];
  assign in_doff   = s_axis_tdata_i[DOFF_LSB +: WORDS_W];
  assign in_port   = s_axis_tdata_i[PORT_LSB +: PORT_W];
  assign in_caplen = s_axis_tdata_i[CAPLEN_LSB +: LEN_W];
  assign in_hdr    = LINK_HEADER_BYTES + {2'b00, in_ihl, 2'b00} + {2'b00, in_doff, 2'b00};

  // Latched time and the derived stamp
  logic [SEC_W-1:0]   sec_q;
  logic [USEC_W-1:0]  usec_q;
  logic [STAMP_W-1:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sec_q  <= s_axis_tdata_i[SEC_LSB +: SEC_W];
      usec_q <= s_axis_tdata_i[USEC_LSB +: USEC_W];
    end
    if (cmd_i.calc) begin
      now_q <= STAMP_W'(sec_q) * STAMP_W'(USEC_PER_SEC) + STAMP_W'(usec_q);
    end
  end

  // Queue pointers and the request counter
  logic [AW-1:0]      head_q, head_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [INDEX_W-1:0] seen_q;
  logic [SW-1:0]      tail_sum;
  logic [AW-1:0]      tail;

  assign tail_sum = SW'(head_q) + SW'(fill_q);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? AW'(tail_sum - SW'(QUEUE_DEPTH))
                                                   : AW'(tail_sum);

  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (cmd_i.pop) begin
      head_d = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
      fill_d = fill_q - FW'(1);
    end else if (cmd_i.push) begin
      fill_d = fill_q + FW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
      seen_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (cmd_i.push) begin
        seen_q <= seen_q + INDEX_W'(1);
      end
    end
  end

  // Time stamp store; the read port follows the next head so that the
  // oldest entry is on rd_stamp in the cycle after every pop.
  logic [STAMP_W-1:0] rd_stamp;

  hrwc_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail),
    .wdata_i (now_q),
    .raddr_i (head_d),
    .rdata_o (rd_stamp)
  );

  // Window test: the new time is at or past oldest + window.
  logic [STAMP_W:0] diff;
  logic             outside;

  assign diff    = {1'b0, now_q} - {1'b0, rd_stamp};
  assign outside = !diff[STAMP_W] && (diff[STAMP_W-1:0] >= STAMP_W'(window_us_i));

  // Hold register keeps the newest result until it is known whether it is
  // the last one of the item.
  logic               hold_valid_q;
  logic [INDEX_W-1:0] hold_idx_q;
  logic [COUNT_W-1:0] hold_cnt_q;
  logic               hold_sat_q;

  logic               out_valid_q;
  logic [INDEX_W-1:0] out_idx_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               out_sat_q;
  logic               out_last_q;
  logic               out_free;
  logic               move_out;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign move_out = (cmd_i.pop && hold_valid_q) || cmd_i.finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.pop) begin
        hold_valid_q <= 1'b1;
      end else if (cmd_i.finish) begin
        hold_valid_q <= 1'b0;
      end
      if (move_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      hold_idx_q <= seen_q - INDEX_W'(fill_q);
      hold_cnt_q <= COUNT_W'(fill_q);
      hold_sat_q <= cmd_i.sat;
    end
    if (move_out) begin
      out_idx_q  <= hold_idx_q;
      out_cnt_q  <= hold_cnt_q;
      out_sat_q  <= hold_sat_q;
      out_last_q <= cmd_i.finish;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_sat_q, out_cnt_q, out_idx_q};
  assign m_axis_tlast_o  = out_last_q;

  // Status to the controller
  always_comb begin
    status_o            = '0;
    status_o.in_cmd     = s_axis_tuser_i;
    status_o.in_req     = (LEN_W'(in_hdr) != in_caplen) && (in_port != excluded_port_i);
    status_o.fill_nz    = (fill_q != '0);
    status_o.full       = (fill_q == FW'(QUEUE_DEPTH));
    status_o.outside    = outside;
    status_o.out_free   = out_free;
    status_o.hold_valid = hold_valid_q;
  end

endmodule

// ===== sv/http_request_window_counter.sv =====
// Sliding-window request counter.
// Input stream: one item per packet (tuser = 0) or an end-of-capture command
// (tuser = 1). A packet whose header sizes disagree with its captured length
// and whose source port is not the excluded one is a request; its time in
// microseconds waits in a QUEUE_DEPTH-entry queue. Each request is reported
// on the output stream, in arrival order, with how many requests started
// within the window from it; tlast marks the final result of an input item.
// Configuration sits on an APB port: window_us at 0x0, excluded_port at 0x4.
// Sequence with a ready receiver: a non-request packet is taken in ST_IDLE.
// A request passes ST_IDLE, ST_CALC, ST_SCAN (one pop per entry that leaves
// its window), ST_PUSH and, when it reports anything, ST_FIN; a flush passes
// ST_IDLE, ST_FLUSH (one pop per waiting entry) and ST_FIN. The queue pops one
// entry per cycle while the output register is free. The newest result of an
// item waits in the hold register until the next pop or ST_FIN moves it out.
// A stalled output holds its result and halts popping; input is refused
// until the item in work is done. Reset empties the queue, zeroes the
// request count and loads window_us = 1000000 and excluded_port = 80.
module http_request_window_counter #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Packet stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // ip_header_words[3:0], tcp_offset_words[7:4], source_port[23:8],
  // captured_length[39:24], stamp_sec[71:40], stamp_usec[91:72], zero pad
  input  logic [hrwc_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // cmd[0]
  input  logic                               s_axis_tuser_i,
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // request_index[31:0], request_count[38:32], saturated[39]
  output logic [hrwc_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hrwc_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [hrwc_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [hrwc_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);

  import hrwc_pkg::*;

  logic [WINDOW_W-1:0] window_us;
  logic [PORT_W-1:0]   excluded_port;
  hrwc_cmd_t           dp_cmd;
  hrwc_status_t        dp_status;

  hrwc_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .window_us_o     (window_us),
    .excluded_port_o (excluded_port)
  );

  hrwc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .status_i        (dp_status),
    .cmd_o           (dp_cmd)
  );

  hrwc_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .status_o        (dp_status),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .window_us_i     (window_us),
    .excluded_port_i (excluded_port),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== tb/http_request_window_counter_test.sv =====
`timescale 1ns / 1ps

module http_request_window_counter_test;
  import hrwc_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 64;
  localparam int unsigned MAX_GAP = 12;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES = 2000;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned REQUEST_GOAL = 300;

  // Kinds of input transfer that the stimulus makes.
  typedef enum {
    PKT_REQUEST,
    PKT_HEADER_ONLY,
    PKT_EXCLUDED,
    PKT_FLUSH
  } pkt_kind_e;

  // One report as it should appear on the result stream.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COUNT_W-1:0] count;
    logic               saturated;
    logic               last;
  } report_t;

  // Tracks the request stamps still open in the window queue and the reports they owe.
  class request_window_tally;
    logic [WINDOW_W-1:0] window_us = WINDOW_RESET;
    logic [PORT_W-1:0]   excluded_port = EXCL_PORT_RESET;
    logic [STAMP_W-1:0]  open_stamps[$];
    logic [INDEX_W-1:0]  requests_seen = '0;
    report_t             due_reports[$];
    int unsigned         request_total = 0;
    int unsigned         report_total = 0;
    int unsigned         saturated_total = 0;
    int unsigned         flush_total = 0;
    int unsigned         error_total = 0;

    function void write_register(hrwc_reg_e idx, logic [APB_DATA_W-1:0] value);
      if (idx == REG_WINDOW_US) begin
        window_us = value[WINDOW_W-1:0];
      end else begin
        excluded_port = value[PORT_W-1:0];
      end
    endfunction

    // The oldest stamp leaves with the number of stamps still open, itself included.
    function void release_oldest(logic sat);
      report_t     r;
      int unsigned fill;
      fill = open_stamps.size();
      r.index = requests_seen - fill[INDEX_W-1:0];
      r.count = fill[COUNT_W-1:0];
      r.saturated = sat;
      r.last = 1'b0;
      void'(open_stamps.pop_front());
      due_reports.insert(due_reports.size(), r);
      if (sat) begin
        saturated_total++;
      end
    endfunction

    // Called for every accepted input transfer.
    function void take_item(logic cmd, logic [IN_DATA_W-1:0] data);
      logic [WORDS_W-1:0] ihl;
      logic [WORDS_W-1:0] doff;
      logic [PORT_W-1:0]  port;
      logic [LEN_W-1:0]   caplen;
      logic [LEN_W-1:0]   hdr;
      logic [SEC_W-1:0]   sec;
      logic [USEC_W-1:0]  usec;
      logic [63:0]        now_wide;
      logic [STAMP_W-1:0] now;
      int unsigned        before_count;
      report_t            tail;
      before_count = due_reports.size();
      ihl = data[IHL_LSB +: WORDS_W];
      doff = data[DOFF_LSB +: WORDS_W];
      port = data[PORT_LSB +: PORT_W];
      caplen = data[CAPLEN_LSB +: LEN_W];
      sec = data[SEC_LSB +: SEC_W];
      usec = data[USEC_LSB +: USEC_W];
      if (cmd) begin
        // End of capture drains the whole queue.
        flush_total++;
        while (open_stamps.size() > 0) begin
          release_oldest(1'b0);
        end
      end else begin
        hdr = {8'b0, LINK_HEADER_BYTES} + {10'b0, ihl, 2'b0} + {10'b0, doff, 2'b0};
        if (hdr == caplen || port == excluded_port) begin
          return;
        end
        now_wide = {32'b0, sec} * {44'b0, USEC_PER_SEC} + {44'b0, usec};
        now = now_wide[STAMP_W-1:0];
        // Stamps whose window the new request has left are reported first.
        while (open_stamps.size() > 0) begin
          if (now < open_stamps[0] || (now - open_stamps[0]) < {20'b0, window_us}) begin
            break;
          end
          release_oldest(1'b0);
        end
        if (open_stamps.size() >= QUEUE_DEPTH) begin
          release_oldest(1'b1);
        end
        open_stamps.insert(open_stamps.size(), now);
        requests_seen++;
        request_total++;
      end
      // Mark the final report of this transfer.
      if (due_reports.size() > before_count) begin
        tail = due_reports[due_reports.size() - 1];
        tail.last = 1'b1;
        due_reports[due_reports.size() - 1] = tail;
      end
    endfunction

    // Called for every accepted result transfer.
    function void match_report(logic [OUT_DATA_W-1:0] data, logic last);
      report_t want;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected result, index %0d count %0d saturated %0b last %0b",
                 $time, data[INDEX_W-1:0], data[INDEX_W +: COUNT_W],
                 data[INDEX_W+COUNT_W], last);
        error_total++;
        return;
      end
      want = due_reports.pop_front();
      report_total++;
      if (data[INDEX_W-1:0] !== want.index) begin
        $display("%0t: request_index expected %0d, actual %0d",
                 $time, want.index, data[INDEX_W-1:0]);
        error_total++;
      end
      if (data[INDEX_W +: COUNT_W] !== want.count) begin
        $display("%0t: request_count expected %0d, actual %0d",
                 $time, want.count, data[INDEX_W +: COUNT_W]);
        error_total++;
      end
      if (data[INDEX_W+COUNT_W] !== want.saturated) begin
        $display("%0t: saturated expected %0b, actual %0b",
                 $time, want.saturated, data[INDEX_W+COUNT_W]);
        error_total++;
      end
      if (last !== want.last) begin
        $display("%0t: tlast expected %0b, actual %0b", $time, want.last, last);
        error_total++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  request_window_tally tally = new;

  // Knobs the stimulus sets per phase.
  int unsigned       src_gap_max = MAX_GAP;
  int unsigned       sink_gap_max = MAX_GAP;
  int unsigned       jump_pct = 9;
  int unsigned       flush_pct = 4;
  longint unsigned   now_us = 0;
  longint unsigned   step_max = 1000;
  bit                hold_go = 1'b0;
  bit                hold_done = 1'b0;
  int unsigned       setting_total = 1;

  http_request_window_counter #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d results still outstanding",
                 $time, tally.due_reports.size());
        $display("http_request_window_counter_test NOT OK");
        $finish;
      end
    end
  end

  // Result side: random stalls per transfer, plus one long hold when asked.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        tally.match_report(m_axis_tdata_o, m_axis_tlast_o);
        stall_left = $urandom_range(sink_gap_max, 0);
      end
      if (hold_go && !hold_done) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Offers one input transfer after a random gap and waits for it to be taken.
  task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] data);
    int unsigned gap;
    gap = $urandom_range(src_gap_max, 0);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= data;
    s_axis_tuser_i <= cmd;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tally.take_item(cmd, data);
  endtask

  task automatic send_fields(input logic cmd, input logic [WORDS_W-1:0] ihl,
                             input logic [WORDS_W-1:0] doff, input logic [PORT_W-1:0] port,
                             input logic [LEN_W-1:0] caplen, input logic [SEC_W-1:0] sec,
                             input logic [USEC_W-1:0] usec);
    logic [IN_DATA_W-1:0] data;
    data = '0;
    data[IHL_LSB +: WORDS_W] = ihl;
    data[DOFF_LSB +: WORDS_W] = doff;
    data[PORT_LSB +: PORT_W] = port;
    data[CAPLEN_LSB +: LEN_W] = caplen;
    data[SEC_LSB +: SEC_W] = sec;
    data[USEC_LSB +: USEC_W] = usec;
    send_item(cmd, data);
  endtask

  // Random packet of the given kind; the capture clock moves on for each non-flush packet.
  task automatic send_packet(input pkt_kind_e kind);
    logic [WORDS_W-1:0] ihl;
    logic [WORDS_W-1:0] doff;
    logic [PORT_W-1:0]  port;
    logic [LEN_W-1:0]   caplen;
    logic [LEN_W-1:0]   hdr;
    logic [SEC_W-1:0]   sec;
    logic [USEC_W-1:0]  usec;
    longint unsigned    w64;
    longint unsigned    back;
    int unsigned        pick;
    ihl = WORDS_W'($urandom);
    doff = WORDS_W'($urandom);
    port = PORT_W'($urandom);
    caplen = LEN_W'($urandom);
    sec = $urandom;
    usec = USEC_W'($urandom);
    if (kind == PKT_FLUSH) begin
      send_fields(1'b1, ihl, doff, port, caplen, sec, usec);
      return;
    end
    // Mostly small steps, sometimes a jump past the window or a step back.
    pick = $urandom_range(99, 0);
    w64 = {32'b0, tally.window_us};
    if (pick < 3) begin
      back = 64'($urandom_range(2000, 0));
      now_us = (now_us > back) ? now_us - back : 64'd0;
    end else if (pick < 3 + jump_pct) begin
      now_us += w64 + ({32'b0, $urandom} % (w64 + 64'd1));
    end else begin
      now_us += {32'b0, $urandom} % (step_max + 64'd1);
    end
    sec = SEC_W'(now_us / 64'd1000000);
    usec = USEC_W'(now_us % 64'd1000000);
    if ($urandom_range(99, 0) < 3) begin
      usec = USEC_W'($urandom_range(20'hFFFFF, 1000000));
    end
    hdr = {8'b0, LINK_HEADER_BYTES} + {10'b0, ihl, 2'b0} + {10'b0, doff, 2'b0};
    case (kind)
      PKT_HEADER_ONLY: begin
        caplen = hdr;
      end
      PKT_EXCLUDED: begin
        port = tally.excluded_port;
      end
      default: begin
        if (caplen == hdr) caplen ^= 16'h0001;
        if (port == tally.excluded_port) port ^= 16'h0001;
      end
    endcase
    send_fields(1'b0, ihl, doff, port, caplen, sec, usec);
  endtask

  // Waits until every owed report has arrived and the block has gone quiet.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (tally.due_reports.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_reg(input hrwc_reg_e idx, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    logic [APB_DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tally.write_register(idx, value);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    want = (idx == REG_WINDOW_US) ? tally.window_us : {16'b0, tally.excluded_port};
    if (readback !== want) begin
      $display("%0t: register %s read expected %0d, actual %0d",
               $time, idx.name(), want, readback);
      tally.error_total++;
    end
  endtask

  initial begin : stimulus
    int unsigned         ph;
    int unsigned         kind;
    int unsigned         target;
    int unsigned         pick;
    logic [WINDOW_W-1:0] w;
    logic [PORT_W-1:0]   port;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed checks at the reset settings: window of one second, port 80 excluded.
    send_fields(1'b0, 4'd5, 4'd5, 16'd1234, 16'd54, 32'd0, 20'd0);     // headers only
    send_fields(1'b0, 4'd5, 4'd8, 16'd80, 16'd1500, 32'd0, 20'd0);     // excluded port
    send_fields(1'b1, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 20'd0);         // flush, empty queue
    send_fields(1'b0, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 32'd0, 20'd0);
    send_fields(1'b0, 4'h0, 4'h0, 16'h0000, 16'h0000, 32'd0, 20'd999999);
    send_fields(1'b0, 4'd5, 4'd5, 16'd443, 16'd60, 32'd1, 20'd0);      // first one leaves
    send_fields(1'b0, 4'd5, 4'd5, 16'd443, 16'd60, 32'd0, 20'd5);      // earlier stamp
    send_fields(1'b0, 4'd5, 4'd5, 16'd443, 16'd60, 32'd0, 20'hFFFFF);  // oversized usec
    send_fields(1'b0, 4'd5, 4'd5, 16'd443, 16'd60, 32'hFFFFFFFF, 20'hFFFFF);
    send_fields(1'b1, 4'hF, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 20'hFFFFF);
    settle();

    // A zero window lets every later stamp out at once.
    write_reg(REG_WINDOW_US, 32'd0);
    write_reg(REG_EXCLUDED_PORT, 32'd0);
    setting_total++;
    repeat (3) send_fields(1'b0, 4'd5, 4'd5, 16'd80, 16'd100, 32'd7, 20'd7);
    send_fields(1'b0, 4'd5, 4'd5, 16'd0, 16'd100, 32'd7, 20'd8);
    send_fields(1'b1, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 20'd0);
    settle();

    // Narrowest nonzero window.
    write_reg(REG_WINDOW_US, 32'd1);
    write_reg(REG_EXCLUDED_PORT, 32'h0000FFFF);
    setting_total++;
    send_fields(1'b0, 4'd6, 4'd5, 16'd8080, 16'd200, 32'd9, 20'd100);
    send_fields(1'b0, 4'd6, 4'd5, 16'd8080, 16'd200, 32'd9, 20'd100);
    send_fields(1'b0, 4'd6, 4'd5, 16'd8080, 16'd200, 32'd9, 20'd101);
    send_fields(1'b1, 4'd0, 4'd0, 16'd0, 16'd0, 32'd0, 20'd0);

    // Random phases, each with its own window, excluded port and pacing.
    ph = 0;
    while (tally.request_total < REQUEST_GOAL) begin
      kind = ph % 6;
      case (kind)
        0: w = $urandom_range(2000000, 1000);
        1: w = 32'hFFFFFFFF;
        2: w = 32'd1;
        3: w = 32'd0;
        4: w = $urandom;
        default: w = $urandom_range(200, 2);
      endcase
      case (ph % 4)
        0: port = 16'hFFFF;
        1: port = 16'h0000;
        2: port = PORT_W'($urandom);
        default: port = EXCL_PORT_RESET;
      endcase
      settle();
      write_reg(REG_WINDOW_US, w);
      write_reg(REG_EXCLUDED_PORT, {16'b0, port});
      setting_total++;

      // The widest window runs dense and unbroken so the queue fills and saturates.
      step_max = (kind == 1 || ph % 2 == 0) ? {32'b0, w >> 7} + 64'd1
                                             : {32'b0, w >> 3} + 64'd1;
      jump_pct = (kind == 1) ? 0 : 9;
      flush_pct = (kind == 1) ? 0 : 4;
      now_us = (ph % 5 == 0) ? 64'd0
                             : 64'($urandom_range(32'hFFF00000, 0)) * 64'd1000000;
      src_gap_max = (ph % 3 == 0) ? 0 : MAX_GAP;
      sink_gap_max = (ph % 4 == 1) ? 0 : MAX_GAP;
      if (kind == 1) begin
        hold_go = 1'b1;
      end
      target = tally.request_total + ((kind == 1) ? 100 : 40);

      while (tally.request_total < target) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
          send_packet(PKT_HEADER_ONLY);
        end else if (pick < 18) begin
          send_packet(PKT_EXCLUDED);
        end else if (pick < 18 + flush_pct) begin
          send_packet(PKT_FLUSH);
        end else begin
          send_packet(PKT_REQUEST);
        end
      end
      // Some phases leave stamps open across the register change.
      if ($urandom_range(9, 0) < 7) begin
        send_packet(PKT_FLUSH);
      end
      ph++;
    end
    send_packet(PKT_FLUSH);
    settle();

    $display("Run covered %0d requests, %0d reports (%0d saturated), %0d flushes,",
             tally.request_total, tally.report_total, tally.saturated_total,
             tally.flush_total);
    $display("under %0d register settings with a long result-side hold.", setting_total);
    if (tally.error_total == 0) begin
      $display("http_request_window_counter_test OK");
    end else begin
      $display("http_request_window_counter_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== http_request_window_counter.f =====
sv/hrwc_pkg.sv
sv/hrwc_ram.sv
sv/hrwc_regs.sv
sv/hrwc_ctrl.sv
sv/hrwc_dp.sv
sv/http_request_window_counter.sv
tb/http_request_window_counter_test.sv
